[design/pure_pursuit_goal_point_unit_defines.svh]
// Assertion macros shared by the goal point unit.
// Needs clk and rst_n in the scope of each use.
`ifndef PURE_PURSUIT_GOAL_POINT_UNIT_DEFINES_SVH
`define PURE_PURSUIT_GOAL_POINT_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ppg_pkg.sv]
// Package of the goal point unit: widths, codes, handshake structs and helpers.
// Used by ppg_mem, ppg_alu and pure_pursuit_goal_point_unit; depends on nothing.
package ppg_pkg;

  localparam int CW  = 32;   // coordinate width
  localparam int IW  = 11;   // index and count width
  localparam int RW  = 128;  // wide result width
  localparam int MW  = 65;   // multiplier operand width
  localparam int SW  = 98;   // signed intersection term width
  localparam int DNW = 97;   // division numerator magnitude width
  localparam int REMW = 68;  // remainder width of divide and root

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [DNW-1:0] Q_LIM = DNW'(64'h4000_0000_0000_0000);

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // Clamp an offset to +-(2^31-1).
  function automatic logic signed [CW-1:0] sat_ofs(input logic signed [CW:0] v);
    logic signed [CW:0] lim;
    lim = (CW+1)'(33'sh0_7FFF_FFFF);
    if (v > lim) return CW'(lim);
    if (v < -lim) return CW'(-lim);
    return CW'(v);
  endfunction

  // Magnitude of a 65-bit signed value.
  function automatic logic [MW-1:0] mag65(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // Clamp a 64-bit goal coordinate to the coordinate range.
  function automatic logic signed [CW-1:0] sat_goal(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) return CW'(hi);
    if (v < lo) return CW'(lo);
    return CW'(v);
  endfunction

endpackage

[design/ppg_mem.sv]
// Waypoint store: one write and one read a cycle, registered read data.
// Depends on ppg_pkg for the coordinate width.
module ppg_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [2*ppg_pkg::CW-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [2*ppg_pkg::CW-1:0]  rd_data
);

  logic [2*ppg_pkg::CW-1:0] mem_r [DEPTH];
  logic [2*ppg_pkg::CW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/ppg_alu.sv]
// Shared bit-serial arithmetic: multiply, divide and integer square root.
// Depends on ppg_pkg for widths, op codes and the request/response structs.
module ppg_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppg_pkg::alu_req_t        req,
  input  logic [ppg_pkg::RW-1:0]   opa,
  input  logic [ppg_pkg::MW-1:0]   opb,
  output ppg_pkg::alu_rsp_t        rsp,
  output logic [ppg_pkg::RW-1:0]   result
);

  logic                       busy_r;
  logic                       done_r;
  logic [1:0]                 op_r;
  logic [6:0]                 cnt_r;
  logic [ppg_pkg::RW-1:0]     acc_r;
  logic [ppg_pkg::RW-1:0]     x_r;
  logic [ppg_pkg::MW-1:0]     y_r;
  logic [ppg_pkg::REMW-1:0]   rem_r;

  logic [ppg_pkg::REMW-1:0]   div_r2;
  logic [ppg_pkg::REMW-1:0]   sq_r2;
  logic [ppg_pkg::REMW-1:0]   sq_trial;

  assign div_r2   = {rem_r[ppg_pkg::REMW-2:0], x_r[ppg_pkg::DNW-1]};
  assign sq_r2    = {rem_r[ppg_pkg::REMW-3:0], x_r[ppg_pkg::RW-1 -: 2]};
  assign sq_trial = ppg_pkg::REMW'({acc_r[63:0], 2'b01});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == ppg_pkg::OP_DIV) ? 7'(ppg_pkg::DNW) : 7'd64;
      end else if (busy_r) begin
        unique case (op_r)
          ppg_pkg::OP_MUL: begin
            if (y_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            cnt_r <= cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      x_r   <= opa;
      y_r   <= opb;
      rem_r <= '0;
    end else if (busy_r) begin
      unique case (op_r)
        ppg_pkg::OP_MUL: begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= x_r << 1;
          y_r <= y_r >> 1;
        end
        ppg_pkg::OP_DIV: begin
          x_r <= x_r << 1;
          if (div_r2 >= ppg_pkg::REMW'(y_r)) begin
            rem_r <= div_r2 - ppg_pkg::REMW'(y_r);
            acc_r <= {acc_r[ppg_pkg::RW-2:0], 1'b1};
          end else begin
            rem_r <= div_r2;
            acc_r <= {acc_r[ppg_pkg::RW-2:0], 1'b0};
          end
        end
        default: begin
          x_r <= x_r << 2;
          if (sq_r2 >= sq_trial) begin
            rem_r <= sq_r2 - sq_trial;
            acc_r <= {acc_r[ppg_pkg::RW-2:0], 1'b1};
          end else begin
            rem_r <= sq_r2;
            acc_r <= {acc_r[ppg_pkg::RW-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = acc_r;

endmodule

[design/pure_pursuit_goal_point_unit.sv]
// Pure pursuit goal point unit: waypoint table, segment walk and goal selection.
// Depends on ppg_pkg, ppg_mem, ppg_alu and pure_pursuit_goal_point_unit_defines.svh.
//
// A write transfer (tuser = 0) stores one waypoint and gives no result. A query
// transfer (tuser = 1) walks the segments from start_index, intersects each with
// the lookahead circle and returns one result with the goal point (0,0 when no
// segment sets it) and the updated index; no new transfer is taken until that
// result is registered. All wide arithmetic goes through one shared bit-serial
// unit, which sets the time a query takes: a multiply stops once its second
// operand has no set bit left, while a divide and the square root step through
// every bit. Segments that are skipped early cost far less than segments that
// are walked in full. Waypoints sit in one synchronous memory, read one entry
// per segment; the table has no reset and a slot must be written before a query
// reads it. waypoint_count lies at byte address 0 of the configuration port and
// is clamped to MAX_POINTS.
`include "pure_pursuit_goal_point_unit_defines.svh"

module pure_pursuit_goal_point_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_tvalid,
  output logic          in_tready,
  // entry_index[9:0], entry_x[41:10], entry_y[73:42], pos_x[105:74],
  // pos_y[137:106], lookahead[168:138], start_index[178:169], zero pad above
  input  logic [183:0]  in_tdata,
  // func[0]
  input  logic          in_tuser,
  // result channel
  output logic          out_tvalid,
  input  logic          out_tready,
  // goal_x[31:0], goal_y[63:32], found_index[74:64], zero pad above
  output logic [79:0]   out_tdata,
  // configuration port
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = ppg_pkg::CW;
  localparam int IW = ppg_pkg::IW;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RDW  = 5'd1;
  localparam logic [4:0] ST_L2   = 5'd2;
  localparam logic [4:0] ST_CHK  = 5'd3;
  localparam logic [4:0] ST_RDN  = 5'd4;
  localparam logic [4:0] ST_A0   = 5'd5;
  localparam logic [4:0] ST_A1   = 5'd6;
  localparam logic [4:0] ST_D0   = 5'd7;
  localparam logic [4:0] ST_D1   = 5'd8;
  localparam logic [4:0] ST_LA   = 5'd9;
  localparam logic [4:0] ST_D2   = 5'd10;
  localparam logic [4:0] ST_SQ   = 5'd11;
  localparam logic [4:0] ST_DDY  = 5'd12;
  localparam logic [4:0] ST_NDX  = 5'd13;
  localparam logic [4:0] ST_T2   = 5'd14;
  localparam logic [4:0] ST_T3   = 5'd15;
  localparam logic [4:0] ST_X1   = 5'd16;
  localparam logic [4:0] ST_X2   = 5'd17;
  localparam logic [4:0] ST_Y1   = 5'd18;
  localparam logic [4:0] ST_Y2   = 5'd19;
  localparam logic [4:0] ST_SEL  = 5'd20;
  localparam logic [4:0] ST_E1A  = 5'd21;
  localparam logic [4:0] ST_E1B  = 5'd22;
  localparam logic [4:0] ST_E2A  = 5'd23;
  localparam logic [4:0] ST_E2B  = 5'd24;
  localparam logic [4:0] ST_CA   = 5'd25;
  localparam logic [4:0] ST_CB   = 5'd26;
  localparam logic [4:0] ST_PICK = 5'd27;
  localparam logic [4:0] ST_NEXT = 5'd28;
  localparam logic [4:0] ST_OUT  = 5'd29;

  localparam logic REG_COUNT = 1'b0;

  // input fields
  logic                  f_func;
  logic [9:0]            f_entry_index;
  logic signed [CW-1:0]  f_entry_x;
  logic signed [CW-1:0]  f_entry_y;
  logic signed [CW-1:0]  f_pos_x;
  logic signed [CW-1:0]  f_pos_y;
  logic [30:0]           f_lookahead;
  logic [9:0]            f_start_index;

  assign f_func        = in_tuser;
  assign f_entry_index = in_tdata[9:0];
  assign f_entry_x     = in_tdata[41:10];
  assign f_entry_y     = in_tdata[73:42];
  assign f_pos_x       = in_tdata[105:74];
  assign f_pos_y       = in_tdata[137:106];
  assign f_lookahead   = in_tdata[168:138];
  assign f_start_index = in_tdata[178:169];

  // control and query state
  logic [4:0]              state_r;
  logic                    launched_r;
  logic [IW-1:0]           count_r;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           found_r;
  logic                    out_valid_r;
  logic signed [CW-1:0]    out_gx_r;
  logic signed [CW-1:0]    out_gy_r;
  logic [IW-1:0]           out_idx_r;

  // walk payload
  logic signed [CW-1:0]    cx_r, cy_r;
  logic [30:0]             l_r;
  logic [61:0]             l2_r;
  logic signed [CW-1:0]    wx_r, wy_r, nx_r, ny_r;
  // waypoint at the found index, the fallback goal when the range test fails
  logic signed [CW-1:0]    fx_r, fy_r;
  logic [ppg_pkg::RW-1:0]  t_r;
  logic [ppg_pkg::MW-1:0]  a_r;
  logic                    dneg_r;
  logic [63:0]             dm_r;
  logic [ppg_pkg::RW-1:0]  la_r;
  logic [ppg_pkg::RW-1:0]  disc_r;
  logic [63:0]             sq_r;
  logic signed [ppg_pkg::SW-1:0] ddy_r, ndx_r, t2_r, t3_r;
  logic signed [63:0]      x1_r, x2_r, y1_r, y2_r;
  logic                    xin_r, yin_r;
  logic [ppg_pkg::RW-1:0]  e1_r, e2_r, c_r;
  logic signed [63:0]      gx_r, gy_r;

  // memory and arithmetic unit
  logic                    mem_wr_en;
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  logic [2*CW-1:0]         mem_rd_data;
  ppg_pkg::alu_req_t       alu_req;
  ppg_pkg::alu_rsp_t       alu_rsp;
  logic [ppg_pkg::RW-1:0]  alu_opa;
  logic [ppg_pkg::MW-1:0]  alu_opb;
  logic [ppg_pkg::RW-1:0]  alu_res;

  logic                    in_fire;
  logic                    out_fire;
  logic                    slot_ok;
  logic [IW-1:0]           cnt_eff;
  logic [IW:0]             idx_inc;
  logic                    arith;
  logic [1:0]              arith_op;

  // segment offsets from the robot
  logic signed [CW-1:0]    p1x, p1y, p2x, p2y;
  logic signed [CW:0]      dx, dy;
  logic [ppg_pkg::MW-1:0]  mdx, mdy, mp1x, mp1y, mp2x, mp2y;
  logic [ppg_pkg::MW-1:0]  me1x, me1y, me2x, me2y, mcx, mcy;

  // divide numerator and signed views of the product
  logic signed [ppg_pkg::SW-1:0]  num;
  logic [ppg_pkg::DNW-1:0]        num_mag;
  logic [ppg_pkg::DNW-1:0]        q_mag;
  logic signed [63:0]             q_s;
  logic signed [63:0]             div_out;
  logic                           psign;
  logic [ppg_pkg::RW-1:0]         prod_s;
  logic [ppg_pkg::RW-1:0]         d_full;
  logic [ppg_pkg::RW-1:0]         sum2;

  // goal selection
  logic                    xin, yin, all_zero;
  logic signed [CW-1:0]    xmin, xmax, ymin, ymax;
  logic                    use1;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign slot_ok  = 17'(f_entry_index) < 17'(MAX_POINTS);
  assign cnt_eff  = (17'(count_r) > 17'(MAX_POINTS)) ? IW'(MAX_POINTS) : count_r;
  assign idx_inc  = (IW+1)'(idx_r) + (IW+1)'(1);

  assign p1x  = ppg_pkg::sat_ofs((CW+1)'(wx_r) - (CW+1)'(cx_r));
  assign p1y  = ppg_pkg::sat_ofs((CW+1)'(wy_r) - (CW+1)'(cy_r));
  assign p2x  = ppg_pkg::sat_ofs((CW+1)'(nx_r) - (CW+1)'(cx_r));
  assign p2y  = ppg_pkg::sat_ofs((CW+1)'(ny_r) - (CW+1)'(cy_r));
  assign dx   = (CW+1)'(p2x) - (CW+1)'(p1x);
  assign dy   = (CW+1)'(p2y) - (CW+1)'(p1y);
  assign mdx  = ppg_pkg::mag65(ppg_pkg::MW'(dx));
  assign mdy  = ppg_pkg::mag65(ppg_pkg::MW'(dy));
  assign mp1x = ppg_pkg::mag65(ppg_pkg::MW'(p1x));
  assign mp1y = ppg_pkg::mag65(ppg_pkg::MW'(p1y));
  assign mp2x = ppg_pkg::mag65(ppg_pkg::MW'(p2x));
  assign mp2y = ppg_pkg::mag65(ppg_pkg::MW'(p2y));
  assign me1x = ppg_pkg::mag65(ppg_pkg::MW'(x1_r) - ppg_pkg::MW'(nx_r));
  assign me1y = ppg_pkg::mag65(ppg_pkg::MW'(y1_r) - ppg_pkg::MW'(ny_r));
  assign me2x = ppg_pkg::mag65(ppg_pkg::MW'(x2_r) - ppg_pkg::MW'(nx_r));
  assign me2y = ppg_pkg::mag65(ppg_pkg::MW'(y2_r) - ppg_pkg::MW'(ny_r));
  assign mcx  = ppg_pkg::mag65(ppg_pkg::MW'(cx_r) - ppg_pkg::MW'(nx_r));
  assign mcy  = ppg_pkg::mag65(ppg_pkg::MW'(cy_r) - ppg_pkg::MW'(ny_r));

  // Select the operation and operands of the current arithmetic step.
  always_comb begin
    arith    = 1'b1;
    arith_op = ppg_pkg::OP_MUL;
    alu_opa  = '0;
    alu_opb  = '0;
    num      = '0;
    unique case (state_r)
      ST_L2:  begin alu_opa = ppg_pkg::RW'(l_r);  alu_opb = ppg_pkg::MW'(l_r); end
      ST_A0:  begin alu_opa = ppg_pkg::RW'(mdx);  alu_opb = mdx;  end
      ST_A1:  begin alu_opa = ppg_pkg::RW'(mdy);  alu_opb = mdy;  end
      ST_D0:  begin alu_opa = ppg_pkg::RW'(mp1x); alu_opb = mp2y; end
      ST_D1:  begin alu_opa = ppg_pkg::RW'(mp2x); alu_opb = mp1y; end
      ST_LA:  begin alu_opa = ppg_pkg::RW'(l2_r); alu_opb = a_r;  end
      ST_D2:  begin alu_opa = ppg_pkg::RW'(dm_r); alu_opb = ppg_pkg::MW'(dm_r); end
      ST_SQ:  begin arith_op = ppg_pkg::OP_SQRT; alu_opa = disc_r; end
      ST_DDY: begin alu_opa = ppg_pkg::RW'(dm_r); alu_opb = mdy; end
      ST_NDX: begin alu_opa = ppg_pkg::RW'(dm_r); alu_opb = mdx; end
      ST_T2:  begin alu_opa = ppg_pkg::RW'(sq_r); alu_opb = mdx; end
      ST_T3:  begin alu_opa = ppg_pkg::RW'(sq_r); alu_opb = mdy; end
      ST_X1:  begin arith_op = ppg_pkg::OP_DIV; num = ddy_r + t2_r; end
      ST_X2:  begin arith_op = ppg_pkg::OP_DIV; num = ddy_r - t2_r; end
      ST_Y1:  begin arith_op = ppg_pkg::OP_DIV; num = ndx_r + t3_r; end
      ST_Y2:  begin arith_op = ppg_pkg::OP_DIV; num = ndx_r - t3_r; end
      ST_E1A: begin alu_opa = ppg_pkg::RW'(me1x); alu_opb = me1x; end
      ST_E1B: begin alu_opa = ppg_pkg::RW'(me1y); alu_opb = me1y; end
      ST_E2A: begin alu_opa = ppg_pkg::RW'(me2x); alu_opb = me2x; end
      ST_E2B: begin alu_opa = ppg_pkg::RW'(me2y); alu_opb = me2y; end
      ST_CA:  begin alu_opa = ppg_pkg::RW'(mcx);  alu_opb = mcx;  end
      ST_CB:  begin alu_opa = ppg_pkg::RW'(mcy);  alu_opb = mcy;  end
      default: arith = 1'b0;
    endcase
    num_mag = num[ppg_pkg::SW-1] ? ppg_pkg::DNW'(-num) : ppg_pkg::DNW'(num);
    if (arith_op == ppg_pkg::OP_DIV) begin
      alu_opa = ppg_pkg::RW'(num_mag);
      alu_opb = a_r;
    end
  end

  // Sign of the product being collected, for the signed terms.
  always_comb begin
    unique case (state_r)
      ST_D0:   psign = p1x[CW-1] ^ p2y[CW-1];
      ST_D1:   psign = p2x[CW-1] ^ p1y[CW-1];
      ST_DDY:  psign = dneg_r ^ dy[CW];
      ST_NDX:  psign = !dneg_r ^ dx[CW];
      ST_T2:   psign = dy[CW] ^ dx[CW];
      default: psign = 1'b0;
    endcase
  end

  assign prod_s  = psign ? -alu_res : alu_res;
  assign d_full  = t_r - prod_s;
  assign sum2    = t_r + alu_res;
  assign q_mag   = (alu_res[ppg_pkg::DNW-1:0] > ppg_pkg::Q_LIM) ? ppg_pkg::Q_LIM
                                                                : alu_res[ppg_pkg::DNW-1:0];
  assign q_s     = num[ppg_pkg::SW-1] ? -(64'(q_mag)) : 64'(q_mag);
  assign div_out = q_s + 64'(cy_r);

  assign xmin = (wx_r < nx_r) ? wx_r : nx_r;
  assign xmax = (wx_r > nx_r) ? wx_r : nx_r;
  assign ymin = (wy_r < ny_r) ? wy_r : ny_r;
  assign ymax = (wy_r > ny_r) ? wy_r : ny_r;
  assign xin  = (x1_r >= 64'(xmin)) && (x1_r <= 64'(xmax));
  assign yin  = (y1_r >= 64'(ymin)) && (y1_r <= 64'(ymax));
  assign all_zero = (x1_r == '0) && (y1_r == '0) && (x2_r == '0) && (y2_r == '0);
  assign use1 = (xin_r && yin_r) ? (e1_r < e2_r) : xin_r;

  assign alu_req.start = arith && !launched_r;
  assign alu_req.op    = arith_op;

  assign mem_wr_en   = in_fire && (f_func == ppg_pkg::FUNC_WRITE) && slot_ok;
  assign mem_rd_en   = (state_r == ST_IDLE) || (state_r == ST_CHK);
  assign mem_rd_addr = (state_r == ST_IDLE) ? AW'(f_start_index) : AW'(idx_inc);

  ppg_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(f_entry_index)),
    .wr_data ({f_entry_y, f_entry_x}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ppg_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_opa),
    .opb    (alu_opb),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  // Sequencer: walk the segments, one arithmetic step at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && (cfg_paddr[2] == REG_COUNT)) begin
        count_r <= cfg_pwdata[IW-1:0];
      end
      // the output step refills the register itself
      if (out_fire && (state_r != ST_OUT)) out_valid_r <= 1'b0;

      if (alu_req.start) launched_r <= 1'b1;

      if (arith && launched_r && alu_rsp.done) begin
        launched_r <= 1'b0;
        unique case (state_r)
          ST_L2:  begin l2_r <= alu_res[61:0]; state_r <= ST_CHK; end
          ST_A0:  begin t_r <= alu_res; state_r <= ST_A1; end
          ST_A1:  begin
            a_r <= sum2[ppg_pkg::MW-1:0];
            // drop zero-length segments
            state_r <= (sum2 == '0) ? ST_NEXT : ST_D0;
          end
          ST_D0:  begin t_r <= prod_s; state_r <= ST_D1; end
          ST_D1:  begin
            dneg_r  <= d_full[ppg_pkg::RW-1];
            dm_r    <= d_full[ppg_pkg::RW-1] ? 64'(-d_full) : d_full[63:0];
            state_r <= ST_LA;
          end
          ST_LA:  begin la_r <= alu_res; state_r <= ST_D2; end
          ST_D2:  begin
            // no real crossing when the discriminant goes negative
            disc_r  <= la_r - alu_res;
            state_r <= (la_r < alu_res) ? ST_NEXT : ST_SQ;
          end
          ST_SQ:  begin sq_r <= alu_res[63:0]; state_r <= ST_DDY; end
          ST_DDY: begin ddy_r <= prod_s[ppg_pkg::SW-1:0]; state_r <= ST_NDX; end
          ST_NDX: begin ndx_r <= prod_s[ppg_pkg::SW-1:0]; state_r <= ST_T2; end
          ST_T2:  begin t2_r <= prod_s[ppg_pkg::SW-1:0]; state_r <= ST_T3; end
          ST_T3:  begin t3_r <= alu_res[ppg_pkg::SW-1:0]; state_r <= ST_X1; end
          ST_X1:  begin x1_r <= q_s + 64'(cx_r); state_r <= ST_X2; end
          ST_X2:  begin x2_r <= q_s + 64'(cx_r); state_r <= ST_Y1; end
          ST_Y1:  begin y1_r <= div_out; state_r <= ST_Y2; end
          ST_Y2:  begin y2_r <= div_out; state_r <= ST_SEL; end
          ST_E1A: begin t_r <= alu_res; state_r <= ST_E1B; end
          ST_E1B: begin e1_r <= sum2; state_r <= ST_E2A; end
          ST_E2A: begin t_r <= alu_res; state_r <= ST_E2B; end
          ST_E2B: begin e2_r <= sum2; state_r <= ST_CA; end
          ST_CA:  begin t_r <= alu_res; state_r <= ST_CB; end
          ST_CB:  begin c_r <= sum2; state_r <= ST_PICK; end
          default: state_r <= state_r;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (f_func == ppg_pkg::FUNC_QUERY)) begin
            cx_r    <= f_pos_x;
            cy_r    <= f_pos_y;
            l_r     <= f_lookahead;
            idx_r   <= IW'(f_start_index);
            found_r <= IW'(f_start_index);
            gx_r    <= '0;
            gy_r    <= '0;
            state_r <= ST_RDW;
          end
        end
        ST_RDW: begin
          wx_r    <= mem_rd_data[CW-1:0];
          wy_r    <= mem_rd_data[2*CW-1:CW];
          fx_r    <= mem_rd_data[CW-1:0];
          fy_r    <= mem_rd_data[2*CW-1:CW];
          state_r <= ST_L2;
        end
        ST_CHK: begin
          state_r <= (idx_inc >= (IW+1)'(cnt_eff)) ? ST_OUT : ST_RDN;
        end
        ST_RDN: begin
          nx_r    <= mem_rd_data[CW-1:0];
          ny_r    <= mem_rd_data[2*CW-1:CW];
          state_r <= ST_A0;
        end
        ST_SEL: begin
          xin_r <= xin;
          yin_r <= yin;
          if (all_zero) begin
            state_r <= ST_NEXT;
          end else if (!(xin || yin)) begin
            // range test fails: fall back to the waypoint at the found index
            gx_r    <= 64'(fx_r);
            gy_r    <= 64'(fy_r);
            state_r <= ST_NEXT;
          end else begin
            state_r <= ST_E1A;
          end
        end
        ST_PICK: begin
          gx_r <= use1 ? x1_r : x2_r;
          gy_r <= use1 ? y1_r : y2_r;
          // stop once the goal is nearer the next waypoint than the robot
          if ((use1 ? e1_r : e2_r) < c_r) begin
            found_r <= idx_r;
            state_r <= ST_OUT;
          end else begin
            found_r <= idx_inc[IW-1:0];
            fx_r    <= nx_r;
            fy_r    <= ny_r;
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          wx_r    <= nx_r;
          wy_r    <= ny_r;
          idx_r   <= idx_inc[IW-1:0];
          state_r <= ST_CHK;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_gx_r    <= ppg_pkg::sat_goal(gx_r);
            out_gy_r    <= ppg_pkg::sat_goal(gy_r);
            out_idx_r   <= found_r;
            state_r     <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_idx_r, out_gy_r, out_gx_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_COUNT) ? 32'(count_r) : 32'd0;

  `PPG_ASSERT_NEXT(a_query_blocks, in_fire && (f_func == ppg_pkg::FUNC_QUERY), !in_tready, "query did not block the input")
  `PPG_ASSERT_NOW(a_out_from_seq, $rose(out_tvalid), $past(state_r) == ST_OUT, "result raised outside the output step")
  `PPG_ASSERT_NOW(a_alu_free, alu_req.start, !alu_rsp.busy, "arithmetic unit started while busy")

endmodule

[test/pure_pursuit_goal_point_unit_checker.sv]
// Scoreboard for the goal point unit: watches the configuration port and both streams.
// Predicts each query result from its own copy of the table; depends on ppg_pkg.
`timescale 1ns / 1ps

module pure_pursuit_goal_point_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [183:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [79:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output int           error_count,
  output int           goals_pending
);

  localparam int      TABLE_DEPTH = 1024;
  localparam int      COUNT_ADDR  = 0;
  localparam longint  OFS_MAX     = 64'sd2147483647;

  typedef logic signed [129:0] wide_t;

  typedef struct packed {
    logic [31:0] gx;
    logic [31:0] gy;
    logic [10:0] idx;
  } goal_t;

  logic signed [31:0] way_x [TABLE_DEPTH];
  logic signed [31:0] way_y [TABLE_DEPTH];
  logic [10:0]        point_count;
  goal_t              goals_due [$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic wide_t root_floor(input wide_t n);
    logic [63:0] r;
    wide_t       c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = wide_t'({66'd0, r | (64'd1 << b)});
      if (c * c <= n) r = r | (64'd1 << b);
    end
    return wide_t'({66'd0, r});
  endfunction

  // Truncating divide by a positive denominator, quotient clamped to +-2^62.
  function automatic longint trunc_div(input wide_t n, input wide_t d);
    wide_t q;
    wide_t qcap;
    qcap = wide_t'(64'sh4000_0000_0000_0000);
    q = n / d;
    if (q > qcap) q = qcap;
    else if (q < -qcap) q = -qcap;
    return longint'(q[63:0]);
  endfunction

  function automatic wide_t dist_sq(input longint x, input longint y,
                                    input longint nx, input longint ny);
    wide_t ex;
    wide_t ey;
    ex = wide_t'(x - nx);
    ey = wide_t'(y - ny);
    return ex * ex + ey * ey;
  endfunction

  function automatic goal_t find_goal(input logic signed [31:0] px, input logic signed [31:0] py,
                                      input logic [30:0] look, input logic [9:0] first_seg);
    goal_t  res;
    longint cx, cy, gx, gy, wx, wy, nx, ny, p1x, p1y, p2x, p2y, dx, dy;
    longint x1, x2, y1, y2;
    int     cnt, cur;
    wide_t  lsq, a, dd, dm, la, d2, sq, ddy, ndx, t2, t3;
    logic   xin, yin, pick1;
    cx = px;
    cy = py;
    gx = 0;
    gy = 0;
    cur = first_seg;
    cnt = point_count > TABLE_DEPTH ? TABLE_DEPTH : point_count;
    lsq = wide_t'({99'd0, look}) * wide_t'({99'd0, look});
    for (int i = first_seg; i + 1 < cnt; i++) begin
      wx = way_x[i];
      wy = way_y[i];
      nx = way_x[i+1];
      ny = way_y[i+1];
      p1x = clamp(wx - cx, -OFS_MAX, OFS_MAX);
      p1y = clamp(wy - cy, -OFS_MAX, OFS_MAX);
      p2x = clamp(nx - cx, -OFS_MAX, OFS_MAX);
      p2y = clamp(ny - cy, -OFS_MAX, OFS_MAX);
      dx = p2x - p1x;
      dy = p2y - p1y;
      a = wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
      if (a == 0) continue;  // zero-length segment
      dd = wide_t'(p1x) * wide_t'(p2y) - wide_t'(p2x) * wide_t'(p1y);
      dm = dd < 0 ? -dd : dd;
      la = lsq * a;
      d2 = dm * dm;
      if (la < d2) continue;  // circle misses the line
      sq = root_floor(la - d2);
      ddy = dd * wide_t'(dy);
      ndx = -dd * wide_t'(dx);
      t2 = (dy < 0 ? -sq : sq) * wide_t'(dx);
      t3 = sq * wide_t'(dy < 0 ? -dy : dy);
      x1 = trunc_div(ddy + t2, a) + cx;
      x2 = trunc_div(ddy - t2, a) + cx;
      y1 = trunc_div(ndx + t3, a) + cy;
      y2 = trunc_div(ndx - t3, a) + cy;
      if (x1 == 0 && y1 == 0 && x2 == 0 && y2 == 0) continue;
      xin = x1 >= (wx < nx ? wx : nx) && x1 <= (wx > nx ? wx : nx);
      yin = y1 >= (wy < ny ? wy : ny) && y1 <= (wy > ny ? wy : ny);
      if (xin || yin) begin
        if (xin && yin) pick1 = dist_sq(x1, y1, nx, ny) < dist_sq(x2, y2, nx, ny);
        else pick1 = xin;
        gx = pick1 ? x1 : x2;
        gy = pick1 ? y1 : y2;
        // stop once the goal is nearer the next waypoint than the robot is
        if (dist_sq(gx, gy, nx, ny) < dist_sq(cx, cy, nx, ny)) begin
          cur = i;
          break;
        end
        cur = i + 1;
      end else begin
        gx = way_x[cur];
        gy = way_y[cur];
      end
    end
    res.gx = 32'(clamp(gx, -64'sd2147483648, 64'sd2147483647));
    res.gy = 32'(clamp(gy, -64'sd2147483648, 64'sd2147483647));
    res.idx = 11'(cur);
    return res;
  endfunction

  always @(posedge clk) begin
    goal_t want;
    goal_t got;
    if (!rst_n) begin
      point_count <= '0;
      goals_due.delete();
      error_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2:2] == COUNT_ADDR)
        point_count <= cfg_pwdata[10:0];
      if (in_tvalid && in_tready) begin
        if (in_tuser == ppg_pkg::FUNC_WRITE) begin
          way_x[in_tdata[9:0]] = in_tdata[41:10];
          way_y[in_tdata[9:0]] = in_tdata[73:42];
        end else begin
          goals_due.push_back(find_goal(in_tdata[105:74], in_tdata[137:106],
                                        in_tdata[168:138], in_tdata[178:169]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.gx = out_tdata[31:0];
        got.gy = out_tdata[63:32];
        got.idx = out_tdata[74:64];
        if (goals_due.size() == 0) begin
          if (error_count < 10) $display("unexpected result %h", out_tdata);
          error_count <= error_count + 1;
        end else begin
          want = goals_due.pop_front();
          if (want != got) begin
            if (error_count < 10)
              $display("goal mismatch: expected x=%h y=%h idx=%0d, got x=%h y=%h idx=%0d",
                       want.gx, want.gy, want.idx, got.gx, got.gy, got.idx);
            error_count <= error_count + 1;
          end
        end
      end
    end
    goals_pending <= goals_due.size();
  end

endmodule

[test/pure_pursuit_goal_point_unit_test.sv]
// Top of the goal point unit testbench: clock, reset, stimulus and verdict.
// Depends on ppg_pkg, pure_pursuit_goal_point_unit and its checker.
`timescale 1ns / 1ps

module pure_pursuit_goal_point_unit_test;

  localparam int  CYCLE_LIMIT = 6000000;
  localparam int  UNIT        = 1 << 16;  // one metre in Q16.16
  localparam logic [2:0] ADDR_COUNT  = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [183:0] in_tdata = '0;
  logic         in_tuser = ppg_pkg::FUNC_WRITE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int error_count;
  int goals_pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // recent path, used to place the robot near it
  logic signed [31:0] path_x [8];
  logic signed [31:0] path_y [8];

  always #6 clk = ~clk;

  pure_pursuit_goal_point_unit dut (.*);

  pure_pursuit_goal_point_unit_checker scoreboard (.*);

  // Receiver: stall at random at the current pressure.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one transfer, idling beforehand at the current rate; return once accepted.
  task automatic send(input logic f, input logic [9:0] eidx, input logic [31:0] ex,
                      input logic [31:0] ey, input logic [31:0] px, input logic [31:0] py,
                      input logic [30:0] look, input logic [9:0] seg);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {5'd0, seg, look, py, px, ey, ex, eidx};
    forever begin
      @(negedge clk) taken = in_tready;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  task automatic put_point(input logic [9:0] slot, input logic [31:0] x, input logic [31:0] y);
    send(ppg_pkg::FUNC_WRITE, slot, x, y, $urandom, $urandom, 31'($urandom), 10'($urandom));
  endtask

  task automatic ask(input logic [31:0] px, input logic [31:0] py, input logic [30:0] look,
                     input logic [9:0] seg);
    send(ppg_pkg::FUNC_QUERY, 10'($urandom), $urandom, $urandom, px, py, look, seg);
  endtask

  // Drop valid, then hold until every expected goal has come back.
  task automatic drain;
    logic busy;
    if (in_tvalid) in_tvalid <= 1'b0;
    busy = 1'b1;
    while (busy) begin
      @(negedge clk) busy = (goals_pending != 0);
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Lay a short random walk of waypoints into consecutive slots from base.
  task automatic lay_path(input int base, input int len);
    logic signed [31:0] x, y;
    x = $signed($urandom_range(100 * UNIT)) - 50 * UNIT;
    y = $signed($urandom_range(100 * UNIT)) - 50 * UNIT;
    for (int k = 0; k < len; k++) begin
      path_x[k % 8] = x;
      path_y[k % 8] = y;
      put_point(10'(base + k), x, y);
      // leave some segments with zero length
      if ($urandom_range(9) != 0) begin
        x = x + $signed($urandom_range(8 * UNIT)) - 4 * UNIT;
        y = y + $signed($urandom_range(8 * UNIT)) - 4 * UNIT;
      end
    end
  endtask

  // Robot near one of the recent waypoints, with a lookahead of a few metres.
  task automatic ask_near(input int len, input int base, input int seg_hi);
    int k;
    k = $urandom_range(len - 1);
    ask(path_x[k % 8] + $signed($urandom_range(4 * UNIT)) - 2 * UNIT,
        path_y[k % 8] + $signed($urandom_range(4 * UNIT)) - 2 * UNIT,
        31'($urandom_range(6 * UNIT, UNIT / 4)), 10'($urandom_range(seg_hi, base)));
  endtask

  initial begin
    int cnt;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing walked, goal stays at the origin
    ask(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 10'd0);
    ask(32'd0, 32'd0, 31'd0, 10'd1023);
    drain();

    // directed path with a zero-length segment and coordinate extremes
    put_point(10'd0, 0, 0);
    put_point(10'd1, 4 * UNIT, 0);
    put_point(10'd2, 4 * UNIT, 0);
    put_point(10'd3, 8 * UNIT, 4 * UNIT);
    put_point(10'd4, 8 * UNIT, 8 * UNIT);
    put_point(10'd5, 32'h7FFF_FFFF, 32'h8000_0000);
    put_point(10'd6, 32'h8000_0000, 32'h7FFF_FFFF);
    put_point(10'd7, 0, 0);
    drain();
    reg_write(ADDR_COUNT, 32'd8);
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    ask(UNIT, 0, 31'(2 * UNIT), 10'd0);
    ask(0, 0, 31'd0, 10'd0);
    ask(5 * UNIT, UNIT, 31'(3 * UNIT), 10'd1);
    ask(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 10'd0);
    ask(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 10'd4);
    ask(100 * UNIT, 100 * UNIT, 31'(UNIT), 10'd0);
    ask(6 * UNIT, 6 * UNIT, 31'(UNIT), 10'd6);
    ask(0, 0, 31'(UNIT), 10'd7);
    drain();

    // random phases cycling through the idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      cnt = (p == 3) ? 1 : $urandom_range(6, 2);
      reg_write(ADDR_COUNT, 32'(cnt));
      lay_path(0, cnt);
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(19))
          0, 1, 2: put_point(10'($urandom), $urandom, $urandom);
          3, 4, 5: ask($urandom, $urandom, 31'($urandom), 10'($urandom));
          default: ask_near(cnt, 0, cnt - 1);
        endcase
        // slot rewrites may have wrecked the path: relay it now and then
        if (n % 10 == 9) lay_path(0, cnt);
      end
      drain();
    end

    // full table and an oversized count, walking only the last segments
    send_idle_pct = 19;
    recv_stall_pct = 19;
    lay_path(1016, 8);
    drain();
    reg_write(ADDR_COUNT, 32'd1024);
    for (int n = 0; n < 6; n++) ask_near(8, 1016, 1023);
    drain();
    reg_write(ADDR_COUNT, 32'd2047);
    for (int n = 0; n < 6; n++) ask_near(8, 1016, 1023);
    drain();

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
